@@ sv/rvaft_pkg.sv @@
`default_nettype none

package rvaft_pkg;

   // Table geometry.
   localparam int MaxSections = 16;
   localparam int IdxW        = (MaxSections > 1) ? $clog2(MaxSections) : 1;
   localparam int CntW        = $clog2(MaxSections + 1);
   localparam int EntryW      = 96;

   // Operation codes on req_func.
   localparam logic [1:0] FN_CLEAR  = 2'd0;
   localparam logic [1:0] FN_APPEND = 2'd1;
   localparam logic [1:0] FN_XLATE  = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_PAST_END  = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // Response kinds chosen by the controller.
   localparam logic [1:0] RS_OK        = 2'd0;
   localparam logic [1:0] RS_FULL      = 2'd1;
   localparam logic [1:0] RS_NOT_FOUND = 2'd2;
   localparam logic [1:0] RS_HIT       = 2'd3;

   typedef struct packed {
      logic       clear;
      logic       append;
      logic       load;
      logic       issue;
      logic       respond;
      logic [1:0] rsp_sel;
   } rvaft_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic last_issue;
      logic s1_hit;
      logic s1_miss_last;
   } rvaft_stat_type;

endpackage

`default_nettype wire

@@ sv/rva_to_file_offset_translator_top.sv @@
// Channel   Direction  Handshake                 Payload
// request   in         start, accepted if !busy  req_func, req_section_*, req_query_address
// response  out        rsp_strobe, one cycle     rsp_status, rsp_file_offset, rsp_hit_index
// csr       in         csr_wr_en                 csr_wr_data (file length)
//
// Clear, append, the unused operation code and a translation on an empty table respond at
// once: the result beat is on the outputs in the cycle after the request beat.
// Other translations read one entry per cycle through a read and compare pipeline: the
// RAM read register, compare stage and result register lie between an entry and its beat.
// Reset is synchronous and clears the entry count, the file length and the control state;
// the table RAM is not cleared. The receiver cannot stall; busy only covers a table scan.
`default_nettype none

module rva_to_file_offset_translator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_section_vaddr,
   input  wire logic [31:0] req_section_vsize,
   input  wire logic [31:0] req_section_raw_offset,
   input  wire logic [31:0] req_query_address,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [32:0]      rsp_file_offset,
   output logic [3:0]       rsp_hit_index
);
   import rvaft_pkg::*;

   // Commands from the controller and status back from the datapath.
   rvaft_cmd_type  cmd;
   rvaft_stat_type stat;

   // The controller decodes each request beat. Operations without a scan respond at once;
   // a translation loads the query address and then steps the table scan, stopping at the
   // first matching entry or after the last entry below the count.
   rvaft_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // The datapath holds the section table, the entry count and the file length, runs the
   // range compare and offset add, and registers the result beat.
   rvaft_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_section_vaddr      (req_section_vaddr),
      .req_section_vsize      (req_section_vsize),
      .req_section_raw_offset (req_section_raw_offset),
      .req_query_address      (req_query_address),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .rsp_strobe             (rsp_strobe),
      .rsp_status             (rsp_status),
      .rsp_file_offset        (rsp_file_offset),
      .rsp_hit_index          (rsp_hit_index)
   );

endmodule

`default_nettype wire

@@ sv/rvaft_ram.sv @@
`default_nettype none

module rvaft_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/rvaft_ctrl.sv @@
`default_nettype none

module rvaft_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [1:0]                req_func,
   input  wire rvaft_pkg::rvaft_stat_type stat,
   output rvaft_pkg::rvaft_cmd_type       cmd,
   output logic                           busy
);
   import rvaft_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic state_ff, state_in;
   logic all_issued_ff, all_issued_in;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      all_issued_in = all_issued_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_func)
                  FN_CLEAR: begin
                     cmd.clear   = 1'b1;
                     cmd.respond = 1'b1;
                     cmd.rsp_sel = RS_OK;
                  end
                  FN_APPEND: begin
                     cmd.respond = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_sel = RS_FULL;
                     end else begin
                        cmd.append  = 1'b1;
                        cmd.rsp_sel = RS_OK;
                     end
                  end
                  FN_XLATE: begin
                     if (stat.empty) begin
                        cmd.respond = 1'b1;
                        cmd.rsp_sel = RS_NOT_FOUND;
                     end else begin
                        cmd.load      = 1'b1;
                        all_issued_in = 1'b0;
                        state_in      = S_SCAN;
                     end
                  end
                  default: begin
                     cmd.respond = 1'b1;
                     cmd.rsp_sel = RS_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd.issue = !all_issued_ff;
            if (cmd.issue && stat.last_issue) begin
               all_issued_in = 1'b1;
            end
            if (stat.s1_hit) begin
               cmd.respond = 1'b1;
               cmd.rsp_sel = RS_HIT;
               state_in    = S_IDLE;
            end else if (stat.s1_miss_last) begin
               cmd.respond = 1'b1;
               cmd.rsp_sel = RS_NOT_FOUND;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         all_issued_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         all_issued_ff <= all_issued_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // A translation against a non-empty table keeps the block busy.
   a_xlate_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FN_XLATE && !stat.empty) |=> busy)
      else $error("translation did not enter the scan");

   // Every response leaves the controller ready for the next beat.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> (state_ff == S_IDLE))
      else $error("controller still busy after responding");

   // The table is only read while a scan is running.
   a_issue_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> busy)
      else $error("table read outside a scan");

endmodule

`default_nettype wire

@@ sv/rvaft_dp.sv @@
`default_nettype none

module rvaft_dp (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rvaft_pkg::rvaft_cmd_type cmd,
   output rvaft_pkg::rvaft_stat_type     stat,
   input  wire logic [31:0]              req_section_vaddr,
   input  wire logic [31:0]              req_section_vsize,
   input  wire logic [31:0]              req_section_raw_offset,
   input  wire logic [31:0]              req_query_address,
   input  wire logic                     csr_wr_en,
   input  wire logic [31:0]              csr_wr_data,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [32:0]                   rsp_file_offset,
   output logic [3:0]                    rsp_hit_index
);
   import rvaft_pkg::*;

   logic [31:0]       file_length_ff;
   logic [CntW-1:0]   count_ff, count_in;
   logic [31:0]       query_ff;
   logic [IdxW-1:0]   scan_idx_ff, scan_idx_in;

   // Read stage: RAM data is valid while rd_vld_ff is set.
   logic              rd_vld_ff, rd_last_ff;
   logic [IdxW-1:0]   rd_idx_ff;
   logic [EntryW-1:0] rd_data;

   // Compare stage.
   logic              s1_vld_ff, s1_hit_ff, s1_last_ff;
   logic [31:0]       s1_diff_ff, s1_raw_ff;
   logic [IdxW-1:0]   s1_idx_ff;

   logic [31:0]       ent_vaddr, ent_vsize, ent_raw, diff;
   logic              in_range;
   logic [32:0]       offset;
   logic              past_end;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [32:0]       rsp_offset_ff, rsp_offset_in;
   logic [3:0]        rsp_index_ff, rsp_index_in;

   rvaft_ram #(
      .WIDTH (EntryW),
      .DEPTH (MaxSections)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[IdxW-1:0]),
      .wr_data ({req_section_vaddr, req_section_vsize, req_section_raw_offset}),
      .rd_en   (cmd.issue),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign ent_vaddr = rd_data[95:64];
   assign ent_vsize = rd_data[63:32];
   assign ent_raw   = rd_data[31:0];
   assign diff      = query_ff - ent_vaddr;
   assign in_range  = (query_ff >= ent_vaddr) && (diff < ent_vsize);

   assign offset    = {1'b0, s1_raw_ff} + {1'b0, s1_diff_ff};
   assign past_end  = (offset >= {1'b0, file_length_ff});

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CntW'(1);
      end
      scan_idx_in = scan_idx_ff;
      if (cmd.load) begin
         scan_idx_in = '0;
      end else if (cmd.issue) begin
         scan_idx_in = scan_idx_ff + IdxW'(1);
      end
   end

   always_comb begin
      rsp_status_in = ST_OK;
      rsp_offset_in = '0;
      rsp_index_in  = '0;
      case (cmd.rsp_sel)
         RS_FULL: begin
            rsp_status_in = ST_FULL;
         end
         RS_NOT_FOUND: begin
            rsp_status_in = ST_NOT_FOUND;
         end
         RS_HIT: begin
            rsp_index_in = 4'(s1_idx_ff);
            if (past_end) begin
               rsp_status_in = ST_PAST_END;
            end else begin
               rsp_offset_in = offset;
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   assign stat.full         = (count_ff == CntW'(MaxSections));
   assign stat.empty        = (count_ff == '0);
   assign stat.last_issue   = ({{(CntW-IdxW){1'b0}}, scan_idx_ff} == (count_ff - CntW'(1)));
   assign stat.s1_hit       = s1_vld_ff && s1_hit_ff;
   assign stat.s1_miss_last = s1_vld_ff && !s1_hit_ff && s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
         count_ff       <= '0;
         rd_vld_ff      <= 1'b0;
         s1_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            file_length_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         rd_vld_ff    <= cmd.issue && !cmd.load;
         s1_vld_ff    <= rd_vld_ff && !cmd.load;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      if (cmd.load) begin
         query_ff <= req_query_address;
      end
      rd_idx_ff  <= scan_idx_ff;
      rd_last_ff <= stat.last_issue;
      s1_hit_ff  <= in_range;
      s1_last_ff <= rd_last_ff;
      s1_diff_ff <= diff;
      s1_raw_ff  <= ent_raw;
      s1_idx_ff  <= rd_idx_ff;
      if (cmd.respond) begin
         rsp_status_ff <= rsp_status_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_index_ff  <= rsp_index_in;
      end
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_file_offset = rsp_offset_ff;
   assign rsp_hit_index   = rsp_index_ff;

   // The entry count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxSections))
      else $error("section count beyond table depth");

   // The compare stage only holds data that came out of the read stage.
   a_pipe_order: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $past(rd_vld_ff))
      else $error("compare stage valid without a read");

   // A past-end result never carries an offset.
   a_past_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_PAST_END) |-> (rsp_offset_ff == '0))
      else $error("past-end result with nonzero offset");

endmodule

`default_nettype wire
